// File: rtl/slac_matching_sequencer_top_defines.svh
// assertion macros for the slac matching sequencer checker
// no dependencies; included by the checker file
`ifndef SLAC_MATCHING_SEQUENCER_TOP_DEFINES_SVH
`define SLAC_MATCHING_SEQUENCER_TOP_DEFINES_SVH

// clocked property, masked while reset is asserted
`define SLAC_MS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked property that also covers the reset cycles
`define SLAC_MS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/slac_ms_pkg.sv
// shared widths, message and status codes and the command type for the sequencer
// no dependencies
package slac_ms_pkg;

    localparam int KIND_W     = 2;
    localparam int MSG_W      = 4;
    localparam int RES_W      = 8;
    localparam int CNT_W      = 5;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ELAPSED_W  = 17;
    localparam int RETRY_W    = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [ELAPSED_W-1:0] LIM_PARM    = 17'd400;
    localparam logic [ELAPSED_W-1:0] ATTEN_EXTRA = 17'd200;
    localparam logic [ELAPSED_W-1:0] LIM_VALID   = 17'd1200;
    localparam logic [ELAPSED_W-1:0] LIM_START   = 17'd800;
    localparam logic [ELAPSED_W-1:0] LIM_RSP     = 17'd800;
    localparam logic [ELAPSED_W-1:0] LIM_VALREQ  = 17'd1500;

    localparam logic [CNT_W-1:0]   SOUND_MAX  = 5'd16;
    localparam logic [CNT_W-1:0]   SOUNDS_SAT = 5'd31;
    localparam logic [RETRY_W-1:0] RETRY_MAX  = 4'd15;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd2;

    localparam logic [MSG_W-1:0] MSG_NONE       = 4'd0;
    localparam logic [MSG_W-1:0] MSG_PARMREQ    = 4'd1;
    localparam logic [MSG_W-1:0] MSG_PARMCNF    = 4'd2;
    localparam logic [MSG_W-1:0] MSG_STARTATTEN = 4'd3;
    localparam logic [MSG_W-1:0] MSG_SOUND      = 4'd4;
    localparam logic [MSG_W-1:0] MSG_ATTENIND   = 4'd5;
    localparam logic [MSG_W-1:0] MSG_ATTENRSP   = 4'd6;
    localparam logic [MSG_W-1:0] MSG_VALREQ     = 4'd7;
    localparam logic [MSG_W-1:0] MSG_VALCNF     = 4'd8;
    localparam logic [MSG_W-1:0] MSG_MATCHREQ   = 4'd9;
    localparam logic [MSG_W-1:0] MSG_MATCHCNF   = 4'd10;

    localparam logic [ST_W-1:0] ST_IDLE     = 2'd0;
    localparam logic [ST_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [ST_W-1:0] ST_MATCHED  = 2'd2;
    localparam logic [ST_W-1:0] ST_FAILED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_TOTAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JOIN_TIMEOUT  = 3'd4;

    typedef enum logic [1:0] {
        BURST_SINGLE = 2'd0,
        BURST_PAIR   = 2'd1,
        BURST_SOUND  = 2'd2
    } t_burst;

    typedef struct packed {
        t_burst           burst;
        logic [MSG_W-1:0] msg;
        logic [CNT_W-1:0] count;
        logic [ST_W-1:0]  status;
    } t_cmd;

endpackage

// File: rtl/slac_ms_in_if.sv
// input channel: start, tick and received frame items
// depends on slac_ms_pkg
interface slac_ms_in_if import slac_ms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [MSG_W-1:0]  rx_msg;
    logic [RES_W-1:0]  rx_result;

    modport source (output valid, kind, rx_msg, rx_result, input ready);
    modport sink   (input valid, kind, rx_msg, rx_result, output ready);
endinterface

// File: rtl/slac_ms_out_if.sv
// output channel: transmit requests with status
// depends on slac_ms_pkg
interface slac_ms_out_if import slac_ms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MSG_W-1:0] tx_msg;
    logic [CNT_W-1:0] tx_count;
    logic [ST_W-1:0]  status;
    logic             last;

    modport source (output valid, tx_msg, tx_count, status, last, input ready);
    modport sink   (input valid, tx_msg, tx_count, status, last, output ready);
endinterface

// File: rtl/slac_ms_front.sv
// front end: configuration registers, protocol state and per-item transmit command
// depends on slac_ms_pkg and slac_ms_in_if
module slac_ms_front import slac_ms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slac_ms_in_if.sink            i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_MATCHED  = 13'b0000000000010,
        PH_FAILED   = 13'b0000000000100,
        PH_V_PARM   = 13'b0000000001000,
        PH_V_ATTEN  = 13'b0000000010000,
        PH_V_VALID  = 13'b0000000100000,
        PH_V_MATCH  = 13'b0000001000000,
        PH_C_PARM   = 13'b0000010000000,
        PH_C_START  = 13'b0000100000000,
        PH_C_SOUNDS = 13'b0001000000000,
        PH_C_RSP    = 13'b0010000000000,
        PH_C_VALREQ = 13'b0100000000000,
        PH_C_MATCH  = 13'b1000000000000
    } t_phase;

    logic                  r_role;
    logic [CNT_W-1:0]      r_sound_total;
    logic [RETRY_W-1:0]    r_retry_limit;
    logic [CFG_DATA_W-1:0] r_sound_tmo;
    logic [CFG_DATA_W-1:0] r_join_tmo;
    logic [ELAPSED_W-1:0]  r_atten_lim;

    t_phase               r_phase, n_phase;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [RETRY_W-1:0]   r_retries, n_retries;
    logic [CNT_W-1:0]     r_sounds, n_sounds;

    logic [ELAPSED_W-1:0] e_inc;
    logic [ELAPSED_W-1:0] limit;
    logic                 in_wait;
    logic [RETRY_W-1:0]   ret_inc;
    logic [CNT_W-1:0]     s_inc;
    logic [CNT_W-1:0]     tot;
    t_burst               c_burst;
    logic [MSG_W-1:0]     c_msg;
    logic [CNT_W-1:0]     c_count;
    logic [ST_W-1:0]      c_status;
    logic                 accept;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;
    assign o_push      = accept;
    assign o_cmd       = '{burst: c_burst, msg: c_msg, count: c_count, status: c_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role        <= 1'b1;
            r_sound_total <= 5'd10;
            r_retry_limit <= 4'd2;
            r_sound_tmo   <= 16'd600;
            r_join_tmo    <= 16'd12000;
            r_atten_lim   <= 17'd800;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROLE:          r_role        <= i_cfg_data[0];
                CFG_SOUND_TOTAL:   r_sound_total <= i_cfg_data[CNT_W-1:0];
                CFG_RETRY_LIMIT:   r_retry_limit <= i_cfg_data[RETRY_W-1:0];
                CFG_SOUND_TIMEOUT: begin
                    r_sound_tmo <= i_cfg_data;
                    r_atten_lim <= {1'b0, i_cfg_data} + ATTEN_EXTRA;
                end
                CFG_JOIN_TIMEOUT:  r_join_tmo    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_sound_total == '0) begin
            tot = CNT_W'(1);
        end else if (r_sound_total > SOUND_MAX) begin
            tot = SOUND_MAX;
        end else begin
            tot = r_sound_total;
        end
    end

    always_comb begin
        in_wait = 1'b1;
        case (r_phase)
            PH_V_PARM:   limit = LIM_PARM;
            PH_V_ATTEN:  limit = r_atten_lim;
            PH_V_VALID:  limit = LIM_VALID;
            PH_V_MATCH:  limit = {1'b0, r_join_tmo};
            PH_C_START:  limit = LIM_START;
            PH_C_SOUNDS: limit = {1'b0, r_sound_tmo};
            PH_C_RSP:    limit = LIM_RSP;
            PH_C_VALREQ: limit = LIM_VALREQ;
            PH_C_MATCH:  limit = {1'b0, r_join_tmo};
            default: begin
                limit   = ELAPSED_MAX;
                in_wait = 1'b0;
            end
        endcase
    end

    always_comb begin
        e_inc   = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
        ret_inc = (r_retries == RETRY_MAX) ? r_retries : r_retries + 1'b1;
        s_inc   = (r_sounds == SOUNDS_SAT) ? r_sounds : r_sounds + 1'b1;

        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_retries = r_retries;
        n_sounds  = r_sounds;
        c_burst   = BURST_SINGLE;
        c_msg     = MSG_NONE;
        c_count   = '0;

        case (i_req.kind)
            KIND_START: begin
                n_retries = '0;
                n_sounds  = '0;
                n_elapsed = '0;
                if (r_role) begin
                    c_msg   = MSG_PARMREQ;
                    n_phase = PH_V_PARM;
                end else begin
                    n_phase = PH_C_PARM;
                end
            end
            KIND_TICK: begin
                n_elapsed = e_inc;
                if (in_wait && (e_inc > limit)) begin
                    if (r_phase == PH_V_PARM) begin
                        n_retries = ret_inc;
                        if (ret_inc >= r_retry_limit) begin
                            n_phase = PH_FAILED;
                        end else begin
                            c_msg     = MSG_PARMREQ;
                            n_elapsed = '0;
                        end
                    end else if ((r_phase == PH_C_SOUNDS) && (r_sounds != '0)) begin
                        c_msg     = MSG_ATTENIND;
                        c_count   = r_sounds;
                        n_phase   = PH_C_RSP;
                        n_elapsed = '0;
                    end else begin
                        n_phase = PH_FAILED;
                    end
                end
            end
            KIND_FRAME: begin
                case (r_phase)
                    PH_V_PARM: begin
                        if (i_req.rx_msg == MSG_PARMCNF) begin
                            c_burst   = BURST_SOUND;
                            c_msg     = MSG_STARTATTEN;
                            c_count   = tot;
                            n_phase   = PH_V_ATTEN;
                            n_elapsed = '0;
                        end
                    end
                    PH_V_ATTEN: begin
                        if (i_req.rx_msg == MSG_ATTENIND) begin
                            c_burst   = BURST_PAIR;
                            c_msg     = MSG_ATTENRSP;
                            n_phase   = PH_V_VALID;
                            n_elapsed = '0;
                        end
                    end
                    PH_V_VALID: begin
                        if (i_req.rx_msg == MSG_VALCNF) begin
                            if (i_req.rx_result == '0) begin
                                c_msg     = MSG_MATCHREQ;
                                n_phase   = PH_V_MATCH;
                                n_elapsed = '0;
                            end else begin
                                n_phase = PH_FAILED;
                            end
                        end
                    end
                    PH_V_MATCH: begin
                        if (i_req.rx_msg == MSG_MATCHCNF) begin
                            n_phase = PH_MATCHED;
                        end
                    end
                    PH_C_PARM: begin
                        if (i_req.rx_msg == MSG_PARMREQ) begin
                            c_msg     = MSG_PARMCNF;
                            n_phase   = PH_C_START;
                            n_elapsed = '0;
                        end
                    end
                    PH_C_START: begin
                        if (i_req.rx_msg == MSG_STARTATTEN) begin
                            n_sounds  = '0;
                            n_phase   = PH_C_SOUNDS;
                            n_elapsed = '0;
                        end
                    end
                    PH_C_SOUNDS: begin
                        if (i_req.rx_msg == MSG_SOUND) begin
                            n_sounds = s_inc;
                            if (s_inc >= tot) begin
                                c_msg     = MSG_ATTENIND;
                                c_count   = s_inc;
                                n_phase   = PH_C_RSP;
                                n_elapsed = '0;
                            end
                        end
                    end
                    PH_C_RSP: begin
                        if (i_req.rx_msg == MSG_ATTENRSP) begin
                            n_phase   = PH_C_VALREQ;
                            n_elapsed = '0;
                        end
                    end
                    PH_C_VALREQ: begin
                        if (i_req.rx_msg == MSG_VALREQ) begin
                            c_msg     = MSG_VALCNF;
                            n_phase   = PH_C_MATCH;
                            n_elapsed = '0;
                        end
                    end
                    PH_C_MATCH: begin
                        if (i_req.rx_msg == MSG_MATCHREQ) begin
                            c_msg   = MSG_MATCHCNF;
                            n_phase = PH_MATCHED;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        case (n_phase)
            PH_IDLE:    c_status = ST_IDLE;
            PH_MATCHED: c_status = ST_MATCHED;
            PH_FAILED:  c_status = ST_FAILED;
            default:    c_status = ST_BUSY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_retries <= '0;
            r_sounds  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_retries <= n_retries;
            r_sounds  <= n_sounds;
        end
    end

endmodule

// File: rtl/slac_ms_queue.sv
// small command queue between the front end and the result generator
// depends on slac_ms_pkg
module slac_ms_queue import slac_ms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/slac_ms_back.sv
// result generator: expands one command into its burst of result items
// depends on slac_ms_pkg and slac_ms_out_if
module slac_ms_back import slac_ms_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    slac_ms_out_if.source o_res
);

    logic             r_busy;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;

    logic             r_ovalid;
    logic [MSG_W-1:0] r_omsg;
    logic [CNT_W-1:0] r_ocnt;
    logic [ST_W-1:0]  r_ost;
    logic             r_olast;

    logic             can_emit;
    logic             emit;
    logic [MSG_W-1:0] g_msg;
    logic [CNT_W-1:0] g_cnt;
    logic             g_last;

    assign o_res.valid    = r_ovalid;
    assign o_res.tx_msg   = r_omsg;
    assign o_res.tx_count = r_ocnt;
    assign o_res.status   = r_ost;
    assign o_res.last     = r_olast;

    assign can_emit = !r_ovalid || o_res.ready;
    assign emit     = r_busy && can_emit;
    assign o_pop    = i_valid && (!r_busy || (emit && g_last));

    always_comb begin
        g_msg  = r_cmd.msg;
        g_cnt  = r_cmd.count;
        g_last = 1'b1;
        case (r_cmd.burst)
            BURST_SINGLE: ;
            BURST_PAIR: begin
                g_msg  = (r_idx == '0) ? MSG_ATTENRSP : MSG_VALREQ;
                g_cnt  = '0;
                g_last = (r_idx != '0);
            end
            BURST_SOUND: begin
                if (r_idx == '0) begin
                    g_msg  = MSG_STARTATTEN;
                    g_cnt  = '0;
                    g_last = 1'b0;
                end else begin
                    g_msg  = MSG_SOUND;
                    g_cnt  = r_cmd.count - r_idx;
                    g_last = (r_idx == r_cmd.count);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_omsg  <= g_msg;
            r_ocnt  <= g_cnt;
            r_ost   <= r_cmd.status;
            r_olast <= g_last;
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (g_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/slac_matching_sequencer_top.sv
// top level of the slac matching sequencer: front end, command queue, result generator
// depends on slac_ms_pkg, both channel interfaces and the three submodules
//
// An input item (start, millisecond tick or received frame) is taken on any cycle in
// which the four-entry command queue has room, so items go in at one per cycle; the
// protocol state is updated in the cycle the item is taken. The result side delivers
// one result item per cycle while the receiver is ready, through a registered output
// stage: most items give one result, a received attenuation indication gives two, and
// a parameter confirm on the vehicle side gives a start-attenuation result plus up to
// sixteen sound results. The sustained rate is one input item per cycle when each gives
// one result and the output is not stalled; bursts are paced by the output register.
// Results cross the queue, the generator's command register and the output register.
// Configuration writes are taken on any cycle and must fall while the block is idle.
module slac_matching_sequencer_top import slac_ms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slac_ms_in_if.sink            i_req,
    slac_ms_out_if.source         o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    slac_ms_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    slac_ms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    slac_ms_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// File: rtl/slac_ms_checker.sv
// port-level checks on the result channel of the sequencer, bound to the top level
// depends on slac_ms_pkg and slac_matching_sequencer_top_defines.svh
`include "slac_matching_sequencer_top_defines.svh"

module slac_ms_checker import slac_ms_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [MSG_W-1:0] i_tx_msg,
    input logic [CNT_W-1:0] i_tx_count,
    input logic [ST_W-1:0]  i_status,
    input logic             i_last
);

    `SLAC_MS_ASSERT_RST(a_rst_clears, !i_rst_n |=> !i_valid, "result valid after reset")
    `SLAC_MS_ASSERT(a_hold, i_valid && !i_ready |=> i_valid && $stable(i_tx_msg) && $stable(i_tx_count) && $stable(i_status) && $stable(i_last), "stalled result changed")
    `SLAC_MS_ASSERT(a_burst_gapless, i_valid && i_ready && !i_last |=> i_valid, "gap inside a result burst")
    `SLAC_MS_ASSERT(a_burst_status, i_valid && i_ready && !i_last |=> i_status == $past(i_status), "status changed inside a burst")

endmodule

bind slac_matching_sequencer_top slac_ms_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_res.valid),
    .i_ready    (o_res.ready),
    .i_tx_msg   (o_res.tx_msg),
    .i_tx_count (o_res.tx_count),
    .i_status   (o_res.status),
    .i_last     (o_res.last)
);

// File: test/slac_matching_sequencer_top_tb.sv
// self-checking testbench for slac_matching_sequencer_top: start, tick and frame items in,
// transmit requests with status out, each checked against a local model of the sequencer or a fixed table row
// depends on slac_ms_pkg, slac_ms_in_if, slac_ms_out_if and the rtl of the top level
module slac_matching_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slac_ms_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
    localparam logic [MSG_W-1:0]     MSG_OTHER    = 4'd11;
    localparam logic [MSG_W-1:0]     MSG_RSVD_TOP = 4'd15;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_RUN_MAX = 16;
    localparam int DIR_ROWS     = 23;
    localparam int RAND_STEPS   = 18;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_MATCHED, SQ_FAILED,
        SQ_V_PARM, SQ_V_ATTEN, SQ_V_VALID, SQ_V_MATCH,
        SQ_C_PARM, SQ_C_START, SQ_C_SOUNDS, SQ_C_RSP, SQ_C_VALREQ, SQ_C_MATCH
    } t_seq_phase;

    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic [CNT_W-1:0] count;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_tx_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MSG_W-1:0]  msg;
        logic [RES_W-1:0]  res;
        logic              typed;
        t_tx_item          want;
    } t_stim_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    slac_ms_in_if  req_ch();
    slac_ms_out_if res_ch();

    slac_matching_sequencer_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the sequencer settings and protocol state
    logic                 cfg_role     = 1'b1;
    logic [CNT_W-1:0]     cfg_sounds   = 5'd10;
    logic [RETRY_W-1:0]   cfg_retry    = 4'd2;
    logic [15:0]          cfg_sound_to = 16'd600;
    logic [15:0]          cfg_join_to  = 16'd12000;
    t_seq_phase           seq_ph       = SQ_IDLE;
    logic [ELAPSED_W-1:0] wait_ms      = '0;
    logic [RETRY_W-1:0]   parm_retries = '0;
    logic [CNT_W-1:0]     sounds_heard = '0;

    t_tx_item  burst_q[$];
    t_tx_item  tx_expected[$];
    t_stim_row dir_rows[DIR_ROWS];
    int        mismatches    = 0;
    int        send_gap_pct  = 25;
    int        take_gap_pct  = 25;
    int        quiet_cycles  = 0;
    bit        hold_request  = 1'b0;

    function automatic void queue_tx(input logic [MSG_W-1:0] m, input logic [CNT_W-1:0] c);
        burst_q.push_back({m, c, ST_IDLE, 1'b0});
    endfunction

    function automatic void enter_wait(input t_seq_phase p);
        seq_ph  = p;
        wait_ms = '0;
    endfunction

    function automatic logic [CNT_W-1:0] sounds_wanted();
        if (cfg_sounds == '0) return 5'd1;
        if (cfg_sounds > SOUND_MAX) return SOUND_MAX;
        return cfg_sounds;
    endfunction

    function automatic logic [ELAPSED_W-1:0] wait_limit(output bit timed);
        timed = 1'b1;
        case (seq_ph)
            SQ_V_PARM:   return LIM_PARM;
            SQ_V_ATTEN:  return ELAPSED_W'(cfg_sound_to) + ATTEN_EXTRA;
            SQ_V_VALID:  return LIM_VALID;
            SQ_V_MATCH:  return ELAPSED_W'(cfg_join_to);
            SQ_C_START:  return LIM_START;
            SQ_C_SOUNDS: return ELAPSED_W'(cfg_sound_to);
            SQ_C_RSP:    return LIM_RSP;
            SQ_C_VALREQ: return LIM_VALREQ;
            SQ_C_MATCH:  return ELAPSED_W'(cfg_join_to);
            default: begin
                timed = 1'b0;
                return '0;
            end
        endcase
    endfunction

    // advances the protocol by one item and leaves the transmit requests in burst_q
    function automatic void sequencer_step(input logic [KIND_W-1:0] k,
                                           input logic [MSG_W-1:0] m,
                                           input logic [RES_W-1:0] r);
        logic [ST_W-1:0]      st;
        logic [ELAPSED_W-1:0] lim;
        bit                   timed;
        burst_q.delete();
        case (k)
            KIND_START: begin
                parm_retries = '0;
                sounds_heard = '0;
                if (cfg_role) begin
                    queue_tx(MSG_PARMREQ, '0);
                    enter_wait(SQ_V_PARM);
                end else begin
                    enter_wait(SQ_C_PARM);
                end
            end
            KIND_TICK: begin
                if (wait_ms != ELAPSED_MAX) wait_ms++;
                lim = wait_limit(timed);
                if (timed && wait_ms > lim) begin
                    if (seq_ph == SQ_V_PARM) begin
                        if (parm_retries != RETRY_MAX) parm_retries++;
                        if (parm_retries >= cfg_retry) begin
                            seq_ph = SQ_FAILED;
                        end else begin
                            queue_tx(MSG_PARMREQ, '0);
                            enter_wait(SQ_V_PARM);
                        end
                    end else if (seq_ph == SQ_C_SOUNDS && sounds_heard != '0) begin
                        queue_tx(MSG_ATTENIND, sounds_heard);
                        enter_wait(SQ_C_RSP);
                    end else begin
                        seq_ph = SQ_FAILED;
                    end
                end
            end
            KIND_FRAME: begin
                case (seq_ph)
                    SQ_V_PARM: if (m == MSG_PARMCNF) begin
                        queue_tx(MSG_STARTATTEN, '0);
                        for (int n = int'(sounds_wanted()); n > 0; n--)
                            queue_tx(MSG_SOUND, CNT_W'(n - 1));
                        enter_wait(SQ_V_ATTEN);
                    end
                    SQ_V_ATTEN: if (m == MSG_ATTENIND) begin
                        queue_tx(MSG_ATTENRSP, '0);
                        queue_tx(MSG_VALREQ, '0);
                        enter_wait(SQ_V_VALID);
                    end
                    SQ_V_VALID: if (m == MSG_VALCNF) begin
                        if (r == '0) begin
                            queue_tx(MSG_MATCHREQ, '0);
                            enter_wait(SQ_V_MATCH);
                        end else begin
                            seq_ph = SQ_FAILED;
                        end
                    end
                    SQ_V_MATCH: if (m == MSG_MATCHCNF) seq_ph = SQ_MATCHED;
                    SQ_C_PARM: if (m == MSG_PARMREQ) begin
                        queue_tx(MSG_PARMCNF, '0);
                        enter_wait(SQ_C_START);
                    end
                    SQ_C_START: if (m == MSG_STARTATTEN) begin
                        sounds_heard = '0;
                        enter_wait(SQ_C_SOUNDS);
                    end
                    SQ_C_SOUNDS: if (m == MSG_SOUND) begin
                        if (sounds_heard != SOUNDS_SAT) sounds_heard++;
                        if (sounds_heard >= sounds_wanted()) begin
                            queue_tx(MSG_ATTENIND, sounds_heard);
                            enter_wait(SQ_C_RSP);
                        end
                    end
                    SQ_C_RSP: if (m == MSG_ATTENRSP) enter_wait(SQ_C_VALREQ);
                    SQ_C_VALREQ: if (m == MSG_VALREQ) begin
                        queue_tx(MSG_VALCNF, '0);
                        enter_wait(SQ_C_MATCH);
                    end
                    SQ_C_MATCH: if (m == MSG_MATCHREQ) begin
                        queue_tx(MSG_MATCHCNF, '0);
                        seq_ph = SQ_MATCHED;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (burst_q.size() == 0) queue_tx(MSG_NONE, '0);
        case (seq_ph)
            SQ_IDLE:    st = ST_IDLE;
            SQ_MATCHED: st = ST_MATCHED;
            SQ_FAILED:  st = ST_FAILED;
            default:    st = ST_BUSY;
        endcase
        foreach (burst_q[i]) begin
            burst_q[i].status = st;
            burst_q[i].last   = (i == burst_q.size() - 1);
        end
    endfunction

    function automatic t_stim_row stim_row(input logic [KIND_W-1:0] k,
                                           input logic [MSG_W-1:0] m,
                                           input logic [RES_W-1:0] r, input logic typed,
                                           input logic [MSG_W-1:0] tx,
                                           input logic [ST_W-1:0] st);
        return '{kind: k, msg: m, res: r, typed: typed, want: {tx, 5'd0, st, 1'b1}};
    endfunction

    // offers one item, waits for it to be taken, then records what it should produce
    task automatic offer_item(input logic [KIND_W-1:0] k, input logic [MSG_W-1:0] m,
                              input logic [RES_W-1:0] r, input logic typed,
                              input t_tx_item fixed);
        while ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= k;
        req_ch.rx_msg    <= m;
        req_ch.rx_result <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sequencer_step(k, m, r);
        if (typed) begin
            tx_expected.push_back(fixed);
        end else begin
            foreach (burst_q[i]) tx_expected.push_back(burst_q[i]);
        end
    endtask

    task automatic drain_results(input int extra);
        req_ch.valid <= 1'b0;
        while (tx_expected.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apply_settings(input logic role, input logic [CNT_W-1:0] sounds,
                                  input logic [RETRY_W-1:0] retry,
                                  input logic [15:0] sound_to, input logic [15:0] join_to,
                                  input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx_list[6];
        logic [CFG_DATA_W-1:0] val_list[6];
        idx_list = '{CFG_ROLE, CFG_SOUND_TOTAL, CFG_RETRY_LIMIT, CFG_SOUND_TIMEOUT,
                     CFG_JOIN_TIMEOUT, CFG_UNUSED};
        val_list = '{CFG_DATA_W'(role), CFG_DATA_W'(sounds), CFG_DATA_W'(retry),
                     sound_to, join_to, 16'hFFFF};
        for (int i = 0; i < (poke_spare ? 6 : 5); i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[i];
            cfg_data <= val_list[i];
            @(posedge clk);
            case (idx_list[i])
                CFG_ROLE:          cfg_role     = val_list[i][0];
                CFG_SOUND_TOTAL:   cfg_sounds   = val_list[i][CNT_W-1:0];
                CFG_RETRY_LIMIT:   cfg_retry    = val_list[i][RETRY_W-1:0];
                CFG_SOUND_TIMEOUT: cfg_sound_to = val_list[i];
                CFG_JOIN_TIMEOUT:  cfg_join_to  = val_list[i];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed protocol traffic, with ticks, timeouts, restarts and noise
    task automatic random_steps(input int n_steps);
        int                   pick;
        int                   run;
        int                   gap;
        bit                   timed;
        logic [ELAPSED_W-1:0] lim;
        logic [KIND_W-1:0]    k;
        logic [MSG_W-1:0]     m;
        logic [RES_W-1:0]     r;
        for (int s = 0; s < n_steps; s++) begin
            pick = $urandom_range(99);
            r    = RES_W'($urandom_range(255));
            if (pick < 8) begin
                offer_item(KIND_W'($urandom_range(3)), MSG_W'($urandom_range(15)), r,
                           1'b0, '0);
            end else if (pick < 12) begin
                offer_item(KIND_START, MSG_W'($urandom_range(15)), r, 1'b0, '0);
            end else if (pick < 30) begin
                lim = wait_limit(timed);
                gap = int'(lim) - int'(wait_ms);
                if (pick < 22 || !timed || gap > LONG_RUN_MAX) run = $urandom_range(1, 6);
                else run = (gap < 0) ? 1 : gap + 1;
                repeat (run) offer_item(KIND_TICK, MSG_W'($urandom_range(15)),
                                        RES_W'($urandom_range(255)), 1'b0, '0);
            end else begin
                k = KIND_FRAME;
                m = MSG_NONE;
                case (seq_ph)
                    SQ_V_PARM:   m = MSG_PARMCNF;
                    SQ_V_ATTEN:  m = MSG_ATTENIND;
                    SQ_V_VALID: begin
                        m = MSG_VALCNF;
                        r = ($urandom_range(3) == 0) ? RES_W'($urandom_range(1, 255)) : '0;
                    end
                    SQ_V_MATCH:  m = MSG_MATCHCNF;
                    SQ_C_PARM:   m = MSG_PARMREQ;
                    SQ_C_START:  m = MSG_STARTATTEN;
                    SQ_C_SOUNDS: m = MSG_SOUND;
                    SQ_C_RSP:    m = MSG_ATTENRSP;
                    SQ_C_VALREQ: m = MSG_VALREQ;
                    SQ_C_MATCH:  m = MSG_MATCHREQ;
                    default:     k = KIND_START;
                endcase
                offer_item(k, m, r, 1'b0, '0);
            end
        end
    endtask

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_tx_item want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (tx_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item: tx_msg %0d tx_count %0d status %0d last %0d",
                         $time, res_ch.tx_msg, res_ch.tx_count, res_ch.status, res_ch.last);
            end else begin
                want = tx_expected.pop_front();
                check_field("tx_msg", want.msg, res_ch.tx_msg);
                check_field("tx_count", want.count, res_ch.tx_count);
                check_field("status", want.status, res_ch.status);
                check_field("last", want.last, res_ch.last);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
            end
            res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    initial begin
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_START;
        req_ch.rx_msg    <= MSG_NONE;
        req_ch.rx_result <= '0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_ROLE;
        cfg_data         <= '0;
        dir_rows = '{
            stim_row(KIND_TICK,  MSG_NONE,       8'h00, 1'b1, MSG_NONE,     ST_IDLE),
            stim_row(KIND_SPARE, MSG_RSVD_TOP,   8'hFF, 1'b1, MSG_NONE,     ST_IDLE),
            stim_row(KIND_FRAME, MSG_OTHER,      8'h00, 1'b1, MSG_NONE,     ST_IDLE),
            stim_row(KIND_START, MSG_NONE,       8'h00, 1'b1, MSG_PARMREQ,  ST_BUSY),
            stim_row(KIND_FRAME, MSG_PARMREQ,    8'h00, 1'b1, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_NONE,       8'h00, 1'b1, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_RSVD_TOP,   8'hFF, 1'b1, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_VALCNF,     8'h80, 1'b1, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_PARMCNF,    8'h00, 1'b0, MSG_NONE,     ST_BUSY),
            stim_row(KIND_TICK,  MSG_NONE,       8'h00, 1'b1, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_ATTENIND,   8'h00, 1'b0, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_VALCNF,     8'hFF, 1'b1, MSG_NONE,     ST_FAILED),
            stim_row(KIND_FRAME, MSG_MATCHCNF,   8'h00, 1'b1, MSG_NONE,     ST_FAILED),
            stim_row(KIND_TICK,  MSG_NONE,       8'h00, 1'b1, MSG_NONE,     ST_FAILED),
            stim_row(KIND_START, MSG_NONE,       8'h00, 1'b1, MSG_PARMREQ,  ST_BUSY),
            stim_row(KIND_FRAME, MSG_PARMCNF,    8'h00, 1'b0, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_ATTENIND,   8'h00, 1'b0, MSG_NONE,     ST_BUSY),
            stim_row(KIND_FRAME, MSG_VALCNF,     8'h00, 1'b1, MSG_MATCHREQ, ST_BUSY),
            stim_row(KIND_FRAME, MSG_MATCHCNF,   8'h00, 1'b1, MSG_NONE,     ST_MATCHED),
            stim_row(KIND_FRAME, MSG_SOUND,      8'h00, 1'b1, MSG_NONE,     ST_MATCHED),
            stim_row(KIND_START, MSG_NONE,       8'h00, 1'b1, MSG_PARMREQ,  ST_BUSY),
            stim_row(KIND_START, MSG_RSVD_TOP,   8'hFF, 1'b1, MSG_PARMREQ,  ST_BUSY),
            stim_row(KIND_FRAME, MSG_PARMCNF,    8'h00, 1'b0, MSG_NONE,     ST_BUSY)
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].kind, dir_rows[i].msg, dir_rows[i].res,
                       dir_rows[i].typed, dir_rows[i].want);
        random_steps(RAND_STEPS);

        // charger, largest sound total, zero timeouts; result side held off for a while
        drain_results(8);
        apply_settings(1'b0, 5'd16, 4'd15, 16'd0, 16'd0, 1'b0);
        hold_request = 1'b1;
        repeat (40) offer_item(KIND_TICK, MSG_NONE, 8'h00, 1'b0, '0);
        random_steps(RAND_STEPS);

        // vehicle, single sound, longest timeouts, no idling on either side
        drain_results(8);
        send_gap_pct = 0;
        take_gap_pct = 0;
        apply_settings(1'b1, 5'd1, 4'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        random_steps(RAND_STEPS);

        drain_results(8);
        send_gap_pct = 25;
        take_gap_pct = 25;
        apply_settings(1'b0, 5'd31, 4'd0, 16'd5, 16'd300, 1'b1);
        random_steps(RAND_STEPS);

        drain_results(8);
        apply_settings(1'b1, 5'd0, 4'd0, 16'd0, 16'd3, 1'b0);
        random_steps(RAND_STEPS);

        drain_results(8);
        apply_settings(1'b1, 5'd20, 4'd15, 16'($urandom_range(65535)),
                       16'($urandom_range(65535)), 1'b0);
        random_steps(RAND_STEPS);

        drain_results(8);
        apply_settings(1'b0, 5'd3, 4'd7, 16'd600, 16'd12000, 1'b0);
        random_steps(RAND_STEPS);

        drain_results(20);
        if (mismatches == 0 && tx_expected.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
